[rtl/ptt_pkg.sv]
// Shared types and codes for the periodic task timer table.
// No dependencies.
package ptt_pkg;

    localparam int FUNC_W   = 3;
    localparam int STATUS_W = 3;
    localparam int TAG_W    = 8;
    localparam int TIME_W   = 32;
    localparam int PEND_W   = 8;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_CLEAR    = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADD      = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_TICK     = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_DISPATCH = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_DELETE   = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_RUN      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NONE_DUE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_SLOT = 3'd4;

    // contents of one slot
    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [TIME_W-1:0] countdown;
        logic [TIME_W-1:0] period;
        logic [PEND_W-1:0] pending;
    } slot_t;

    // command broadcast to every cell
    typedef struct packed {
        logic        tick;   // count down all occupied cells
        logic        load;   // write new entry into the cell at load index
        logic        shift;  // cells at and above shift index take their upper neighbor
        logic        dec;    // decrement pending at head index
    } cell_cmd_t;

endpackage

[rtl/ptt_div.sv]
// Divides delay and period by the fixed tick length: reciprocal multiply, then
// two compare-and-subtract correction steps. Depends on ptt_pkg.
module ptt_div
    import ptt_pkg::*;
#(
    parameter int TICK_MS = 10
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [TIME_W-1:0] num_a,
    input  logic [TIME_W-1:0] num_b,
    output logic              done,
    output logic [TIME_W-1:0] quo_a,
    output logic [TIME_W-1:0] quo_b
);
    // floor((2^32 - 1) / TICK_MS): estimate is at most two below the quotient
    localparam logic [2*TIME_W-1:0] RECIP_FULL =
        (((2*TIME_W)'(1) << TIME_W) - (2*TIME_W)'(1)) / (2*TIME_W)'(TICK_MS);
    localparam logic [TIME_W-1:0] RECIP   = RECIP_FULL[TIME_W-1:0];
    localparam logic [TIME_W-1:0] DIVISOR = TIME_W'(TICK_MS);

    logic [TIME_W-1:0]   na_reg, nb_reg, na_next, nb_next;
    logic [TIME_W-1:0]   qa_reg, qb_reg, qa_next, qb_next;
    logic [1:0]          step_reg, step_next;
    logic                busy_reg, busy_next;
    logic [2*TIME_W-1:0] pa, pb;
    logic [TIME_W-1:0]   ra, rb;

    // step 0: quotient estimate; steps 1 and 2: bump while remainder >= divisor
    always_comb begin
        na_next   = na_reg;
        nb_next   = nb_reg;
        qa_next   = qa_reg;
        qb_next   = qb_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        pa = (2*TIME_W)'(na_reg) * (2*TIME_W)'(RECIP);
        pb = (2*TIME_W)'(nb_reg) * (2*TIME_W)'(RECIP);
        ra = na_reg - qa_reg * DIVISOR;
        rb = nb_reg - qb_reg * DIVISOR;
        if (start) begin
            na_next   = num_a;
            nb_next   = num_b;
            step_next = 2'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            case (step_reg)
                2'd0: begin
                    qa_next   = pa[2*TIME_W-1:TIME_W];
                    qb_next   = pb[2*TIME_W-1:TIME_W];
                    step_next = 2'd1;
                end
                default: begin
                    if (ra >= DIVISOR) begin
                        qa_next = qa_reg + 1'b1;
                    end
                    if (rb >= DIVISOR) begin
                        qb_next = qb_reg + 1'b1;
                    end
                    step_next = step_reg + 1'b1;
                    if (step_reg == 2'd2) begin
                        busy_next = 1'b0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        na_reg <= na_next;
        nb_reg <= nb_next;
        qa_reg <= qa_next;
        qb_reg <= qb_next;
        if (!aresetn) begin
            step_reg <= '0;
            busy_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            busy_reg <= busy_next;
        end
    end

    assign done  = busy_reg && (step_reg == 2'd2);
    assign quo_a = qa_next;
    assign quo_b = qb_next;

endmodule

[rtl/ptt_cell.sv]
// One table slot: holds a task entry, counts down on tick, shifts from its
// upper neighbor on compaction. Depends on ptt_pkg.
module ptt_cell
    import ptt_pkg::*;
(
    input  logic      aclk,
    input  cell_cmd_t cmd,
    input  logic      occupied,   // slot below the fill count
    input  logic      sel_load,   // this cell is the load target
    input  logic      sel_shift,  // this cell is at or above the shift index
    input  logic      sel_dec,    // this cell is the dispatch head
    input  slot_t     load_data,
    input  slot_t     upper,      // neighbor above
    output slot_t     cur
);
    slot_t cell_reg, cell_next;

    always_comb begin
        cell_next = cell_reg;
        if (cmd.load && sel_load) begin
            cell_next = load_data;
        end else if (cmd.shift && sel_shift) begin
            cell_next = upper;
        end else if (cmd.tick && occupied) begin
            if (cell_reg.countdown != '0) begin
                cell_next.countdown = cell_reg.countdown - 1'b1;
            end else begin
                cell_next.countdown = cell_reg.period;
                if (cell_reg.pending != '1) begin
                    cell_next.pending = cell_reg.pending + 1'b1;
                end
            end
        end else if (cmd.dec && sel_dec) begin
            cell_next.pending = cell_reg.pending - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        cell_reg <= cell_next;
    end

    assign cur = cell_reg;

endmodule

[rtl/periodic_task_timer_table_core.sv]
// Top level of the periodic task timer table: control sequencer, divider and
// a row of ptt_cell slots. Depends on ptt_pkg, ptt_cell, ptt_div.
//
// One operation is taken at a time, and only while the output register is
// free or being emptied. Clear, tick, delete and rejected operations finish in
// the accept cycle; the result is valid on the next cycle. A tick updates every
// used slot in parallel; delete compacts the row in that same cycle. Add passes
// through the divider (reciprocal multiply and two corrections) before the entry
// loads. Dispatch walks from slot 0, one slot per cycle while not stalled, with
// a shift step for each one-shot task it removes and a close-out step once past
// the table end or at RESULT_CAP results. Each found task is held back one step
// so the last one can carry tlast; the walk stalls while a result waits to go
// out and the output register is full.
module periodic_task_timer_table_core
    import ptt_pkg::*;
#(
    parameter int MAX_TASKS = 16,
    parameter int TICK_MS   = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // func[2:0], task_tag, delay_ms, period_ms, slot[78:75]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // status[2:0], run_tag[10:3], task_count[15:11]
    output logic        m_tlast
);
    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam int RES_W = 5;
    localparam logic [RES_W-1:0] RESULT_CAP = 5'd16;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_SCAN = 4'b0100,
        S_SHFT = 4'b1000
    } state_t;

    logic [FUNC_W-1:0] in_func;
    logic [TAG_W-1:0]  in_tag;
    logic [TIME_W-1:0] in_delay, in_period;
    logic [3:0]        in_slot;
    assign in_func   = s_tdata[2:0];
    assign in_tag    = s_tdata[10:3];
    assign in_delay  = s_tdata[42:11];
    assign in_period = s_tdata[74:43];
    assign in_slot   = s_tdata[78:75];

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  head_reg, head_next;
    logic [RES_W-1:0]  nres_reg, nres_next;
    logic [TAG_W-1:0]  tag_reg;
    logic              ovalid_reg, ovalid_next;
    logic [STATUS_W-1:0] ost_reg, ost_next;
    logic [TAG_W-1:0]  otag_reg, otag_next;
    logic [CNT_W-1:0]  ocnt_reg, ocnt_next;
    logic              olast_reg, olast_next;
    logic              hvalid_reg, hvalid_next;
    logic [TAG_W-1:0]  htag_reg, htag_next;
    logic [CNT_W-1:0]  hcnt_reg, hcnt_next;

    cell_cmd_t         cmd;
    logic [IDX_W-1:0]  shift_idx;
    slot_t             load_data;
    slot_t             cells [MAX_TASKS];
    logic              div_start, div_done;
    logic [TIME_W-1:0] quo_a, quo_b;

    logic in_fire, out_free;
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !ovalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;

    // the slot at the dispatch head
    slot_t head_cell;
    logic  head_in;
    assign head_cell = cells[head_reg[IDX_W-1:0]];
    assign head_in   = head_reg < count_reg;

    ptt_div #(.TICK_MS(TICK_MS)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num_a(in_delay), .num_b(in_period),
        .done(div_done), .quo_a(quo_a), .quo_b(quo_b)
    );

    assign load_data = '{tag: tag_reg, countdown: quo_a, period: quo_b, pending: '0};

    // row of cells, each fed by its upper neighbor (the top cell by itself)
    genvar g;
    generate
        for (g = 0; g < MAX_TASKS; g++) begin : g_cell
            slot_t up;
            if (g == MAX_TASKS - 1) begin : g_top
                assign up = cells[g];
            end else begin : g_mid
                assign up = cells[g+1];
            end
            ptt_cell u_cell (
                .aclk(aclk), .cmd(cmd),
                .occupied(32'(g) < 32'(count_reg)),
                .sel_load(32'(g) == 32'(count_reg)),
                .sel_shift(32'(g) >= 32'(shift_idx)),
                .sel_dec(32'(g) == 32'(head_reg)),
                .load_data(load_data), .upper(up), .cur(cells[g])
            );
        end
    endgenerate

    // control sequencer
    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        head_next   = head_reg;
        nres_next   = nres_reg;
        ovalid_next = ovalid_reg && !m_tready;
        ost_next    = ost_reg;
        otag_next   = otag_reg;
        ocnt_next   = ocnt_reg;
        olast_next  = olast_reg;
        hvalid_next = hvalid_reg;
        htag_next   = htag_reg;
        hcnt_next   = hcnt_reg;
        cmd         = '0;
        shift_idx   = head_reg[IDX_W-1:0];
        div_start   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    ovalid_next = 1'b1;
                    ost_next    = ST_DONE;
                    otag_next   = '0;
                    olast_next  = 1'b1;
                    ocnt_next   = count_reg;
                    case (in_func)
                        FUNC_CLEAR: begin
                            count_next = '0;
                            ocnt_next  = '0;
                        end
                        FUNC_ADD: begin
                            if (32'(count_reg) < MAX_TASKS) begin
                                ovalid_next = 1'b0;
                                div_start   = 1'b1;
                                state_next  = S_DIV;
                            end else begin
                                ost_next = ST_FULL;
                            end
                        end
                        FUNC_TICK: cmd.tick = 1'b1;
                        FUNC_DISPATCH: begin
                            ovalid_next = 1'b0;
                            hvalid_next = 1'b0;
                            head_next   = '0;
                            nres_next   = '0;
                            state_next  = S_SCAN;
                        end
                        FUNC_DELETE: begin
                            if (32'(in_slot) < 32'(count_reg)) begin
                                cmd.shift  = 1'b1;
                                shift_idx  = IDX_W'(in_slot);
                                count_next = count_reg - 1'b1;
                                ocnt_next  = count_reg - 1'b1;
                            end else begin
                                ost_next = ST_BAD_SLOT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_DIV: begin
                if (div_done) begin
                    cmd.load    = 1'b1;
                    count_next  = count_reg + 1'b1;
                    ovalid_next = 1'b1;
                    ost_next    = ST_DONE;
                    otag_next   = '0;
                    ocnt_next   = count_reg + 1'b1;
                    olast_next  = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_SCAN: begin
                if (!head_in || nres_reg == RESULT_CAP) begin
                    // walk finished: the held run result, or nothing due, goes out last
                    if (out_free) begin
                        ovalid_next = 1'b1;
                        olast_next  = 1'b1;
                        hvalid_next = 1'b0;
                        state_next  = S_IDLE;
                        if (hvalid_reg) begin
                            ost_next  = ST_RUN;
                            otag_next = htag_reg;
                            ocnt_next = hcnt_reg;
                        end else begin
                            ost_next  = ST_NONE_DUE;
                            otag_next = '0;
                            ocnt_next = count_reg;
                        end
                    end
                end else if (head_cell.pending != '0) begin
                    // a due task: release the previous one, hold this one
                    if (!hvalid_reg || out_free) begin
                        if (hvalid_reg) begin
                            ovalid_next = 1'b1;
                            ost_next    = ST_RUN;
                            otag_next   = htag_reg;
                            ocnt_next   = hcnt_reg;
                            olast_next  = 1'b0;
                        end
                        hvalid_next = 1'b1;
                        htag_next   = head_cell.tag;
                        nres_next   = nres_reg + 1'b1;
                        cmd.dec     = 1'b1;
                        if (head_cell.period == '0) begin
                            state_next = S_SHFT;
                            count_next = count_reg - 1'b1;
                            hcnt_next  = count_reg - 1'b1;
                        end else begin
                            hcnt_next = count_reg;
                            head_next = head_reg + 1'b1;
                        end
                    end
                end else begin
                    head_next = head_reg + 1'b1;
                end
            end
            S_SHFT: begin
                cmd.shift  = 1'b1;
                state_next = S_SCAN;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        ost_reg  <= ost_next;
        otag_reg <= otag_next;
        ocnt_reg <= ocnt_next;
        htag_reg <= htag_next;
        hcnt_reg <= hcnt_next;
        if (state_reg == S_IDLE && in_fire) begin
            tag_reg <= in_tag;
        end
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            head_reg   <= '0;
            nres_reg   <= '0;
            ovalid_reg <= 1'b0;
            olast_reg  <= 1'b0;
            hvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            head_reg   <= head_next;
            nres_reg   <= nres_next;
            ovalid_reg <= ovalid_next;
            olast_reg  <= olast_next;
            hvalid_reg <= hvalid_next;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {5'(ocnt_reg), otag_reg, ost_reg};
    assign m_tlast  = olast_reg;

    // fill count never exceeds the table size
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= MAX_TASKS) else $error("fill count above table size");

    // input is taken only while the sequencer is idle
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (state_reg == S_IDLE)) else $error("accepted while busy");

    // an add that completes grows the table by one
    a_add_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV && div_done) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("add did not grow table");

endmodule

[verif/periodic_task_timer_table_core_test.sv]
// Self-checking testbench for periodic_task_timer_table_core: directed table, then random ops,
// each checked against a cycle-free task table predictor. Depends on ptt_pkg and the core RTL.
module periodic_task_timer_table_core_test;
    import ptt_pkg::*;

    localparam int SLOTS    = 16;
    localparam int TICK_DIV = 10;
    localparam int RUN_CAP  = 16;
    localparam int RANDOM_OPS = 160;

    typedef struct {
        logic [2:0]  status;
        logic [7:0]  run_tag;
        logic [4:0]  task_count;
        logic        last;
    } outcome_t;

    typedef struct {
        logic [2:0]  func;
        logic [7:0]  tag;
        logic [31:0] delay_ms;
        logic [31:0] period_ms;
        logic [3:0]  slot;
        bit          typed;       // expected result written in the row
        logic [2:0]  exp_status;
        logic [4:0]  exp_count;
    } op_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;

    // predictor copy of the task table
    logic [7:0]  tbl_tag [SLOTS];
    logic [31:0] tbl_count_down [SLOTS];
    logic [31:0] tbl_period [SLOTS];
    logic [7:0]  tbl_pending [SLOTS];
    int          tbl_used = 0;

    outcome_t outcome_q[$];
    op_row_t  plan[$];
    int       errors = 0;
    bit       quiet = 1'b0;   // no idling in the last part of the run

    periodic_task_timer_table_core #(.MAX_TASKS(SLOTS), .TICK_MS(TICK_DIV)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always #4 aclk = ~aclk;

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    // close the gap left by a removed slot
    task automatic table_remove(input int pos);
        for (int i = pos; i + 1 < tbl_used; i++) begin
            tbl_tag[i]        = tbl_tag[i+1];
            tbl_count_down[i] = tbl_count_down[i+1];
            tbl_period[i]     = tbl_period[i+1];
            tbl_pending[i]    = tbl_pending[i+1];
        end
        if (tbl_used > 0) tbl_used--;
    endtask

    // apply one operation to the table and queue the results it causes
    task automatic table_apply(input op_row_t op);
        outcome_t r;
        logic [2:0] st;
        int i;
        int n;
        st = ST_DONE;
        n = 0;
        case (op.func)
            FUNC_CLEAR: tbl_used = 0;
            FUNC_ADD: begin
                if (tbl_used < SLOTS) begin
                    tbl_tag[tbl_used]        = op.tag;
                    tbl_count_down[tbl_used] = op.delay_ms / TICK_DIV;
                    tbl_period[tbl_used]     = op.period_ms / TICK_DIV;
                    tbl_pending[tbl_used]    = '0;
                    tbl_used++;
                end else begin
                    st = ST_FULL;
                end
            end
            FUNC_TICK: begin
                for (i = 0; i < tbl_used; i++) begin
                    if (tbl_count_down[i] > 0) begin
                        tbl_count_down[i]--;
                    end else begin
                        tbl_count_down[i] = tbl_period[i];
                        if (tbl_pending[i] != 8'hff) tbl_pending[i]++;
                    end
                end
            end
            FUNC_DISPATCH: begin
                i = 0;
                while (i < tbl_used && n < RUN_CAP) begin
                    if (tbl_pending[i] > 0) begin
                        r.run_tag = tbl_tag[i];
                        tbl_pending[i]--;
                        // one-shot: remove and recheck the same position
                        if (tbl_period[i] == 0) table_remove(i);
                        else i++;
                        r.status = ST_RUN;
                        r.task_count = tbl_used[4:0];
                        r.last = 1'b0;
                        outcome_q.push_back(r);
                        n++;
                    end else begin
                        i++;
                    end
                end
                if (n == 0) st = ST_NONE_DUE;
            end
            FUNC_DELETE: begin
                if (op.slot < tbl_used) table_remove(op.slot);
                else st = ST_BAD_SLOT;
            end
            default: ;
        endcase
        if (n == 0) begin
            r.status = st;
            r.run_tag = '0;
            r.task_count = tbl_used[4:0];
            r.last = 1'b0;
            if (op.typed) begin
                r.status = op.exp_status;
                r.task_count = op.exp_count;
            end
            outcome_q.push_back(r);
        end
        outcome_q[$].last = 1'b1;
    endtask

    // one input transfer, with an optional random gap first
    task automatic send(input op_row_t op);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, op.slot, op.period_ms, op.delay_ms, op.tag, op.func};
        do @(posedge aclk); while (!s_tready);
        table_apply(op);
    endtask

    function automatic op_row_t row(input logic [2:0] f, input logic [7:0] t,
                                    input logic [31:0] d, input logic [31:0] p,
                                    input logic [3:0] s);
        op_row_t o;
        o.func = f; o.tag = t; o.delay_ms = d; o.period_ms = p; o.slot = s;
        o.typed = 1'b0; o.exp_status = ST_DONE; o.exp_count = '0;
        return o;
    endfunction

    function automatic op_row_t known(input op_row_t o, input logic [2:0] st,
                                      input logic [4:0] cnt);
        o.typed = 1'b1; o.exp_status = st; o.exp_count = cnt;
        return o;
    endfunction

    // result side: random stall bursts
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                hold = $urandom_range(1, 15) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // result check against the oldest expectation
    always @(posedge aclk) begin
        outcome_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (outcome_q.size() == 0) begin
                report($sformatf("unexpected result %h", m_tdata));
            end else begin
                e = outcome_q.pop_front();
                if (m_tdata[2:0] !== e.status)
                    report($sformatf("status %0d, want %0d", m_tdata[2:0], e.status));
                if (m_tdata[10:3] !== e.run_tag)
                    report($sformatf("run_tag %0d, want %0d", m_tdata[10:3], e.run_tag));
                if (m_tdata[15:11] !== e.task_count)
                    report($sformatf("task_count %0d, want %0d", m_tdata[15:11], e.task_count));
                if (m_tlast !== e.last)
                    report($sformatf("last %b, want %b", m_tlast, e.last));
            end
        end
    end

    // watchdog
    initial begin
        #24000000;
        $display("periodic_task_timer_table_core regression: fail");
        $finish;
    end

    initial begin
        op_row_t op;
        int pick;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        plan.push_back(known(row(FUNC_CLEAR, 8'h00, 0, 0, 4'h0), ST_DONE, 5'd0));
        plan.push_back(known(row(FUNC_DELETE, 8'h00, 0, 0, 4'h0), ST_BAD_SLOT, 5'd0));
        plan.push_back(known(row(FUNC_DISPATCH, 8'h00, 0, 0, 4'h0), ST_NONE_DUE, 5'd0));
        plan.push_back(known(row(FUNC_ADD, 8'h00, 0, 0, 4'h0), ST_DONE, 5'd1));
        plan.push_back(known(row(FUNC_ADD, 8'hff, 32'hffffffff, 32'hffffffff, 4'hf),
                             ST_DONE, 5'd2));
        plan.push_back(known(row(FUNC_ADD, 8'ha5, 10, 10, 4'h0), ST_DONE, 5'd3));
        plan.push_back(known(row(FUNC_ADD, 8'h5a, 9, 19, 4'h0), ST_DONE, 5'd4));
        plan.push_back(row(FUNC_TICK, 8'h00, 0, 0, 4'h0));
        plan.push_back(row(FUNC_DISPATCH, 8'h00, 0, 0, 4'h0));
        plan.push_back(row(FUNC_TICK, 8'h00, 0, 0, 4'h0));
        plan.push_back(row(FUNC_TICK, 8'h00, 0, 0, 4'h0));
        plan.push_back(row(FUNC_DISPATCH, 8'h00, 0, 0, 4'h0));
        plan.push_back(row(3'd5, 8'h11, 0, 0, 4'h0));
        plan.push_back(row(3'd6, 8'h22, 0, 0, 4'h0));
        plan.push_back(row(3'd7, 8'h33, 0, 0, 4'h0));
        plan.push_back(row(FUNC_DELETE, 8'h00, 0, 0, 4'hf));
        plan.push_back(row(FUNC_DELETE, 8'h00, 0, 0, 4'h0));
        plan.push_back(row(FUNC_CLEAR, 8'h00, 0, 0, 4'h0));
        foreach (plan[k]) send(plan[k]);

        // fill the table, then one add too many, a tick and a dispatch, then a delete at slot 15
        for (int k = 0; k < SLOTS; k++)
            send(row(FUNC_ADD, k[7:0], k * 10, (k % 3) * 10, 4'h0));
        send(known(row(FUNC_ADD, 8'h77, 0, 0, 4'h0), ST_FULL, 5'd16));
        send(row(FUNC_TICK, 8'h00, 0, 0, 4'h0));
        send(row(FUNC_DISPATCH, 8'h00, 0, 0, 4'h0));
        send(row(FUNC_DELETE, 8'h00, 0, 0, 4'hf));

        // pending count saturation on two tasks that are due every tick
        send(row(FUNC_CLEAR, 8'h00, 0, 0, 4'h0));
        send(row(FUNC_ADD, 8'hc3, 0, 9, 4'h0));
        send(row(FUNC_ADD, 8'h3c, 0, 5, 4'h0));
        repeat (260) send(row(FUNC_TICK, 8'h00, 0, 0, 4'h0));
        send(row(FUNC_DISPATCH, 8'h00, 0, 0, 4'h0));
        send(row(FUNC_DISPATCH, 8'h00, 0, 0, 4'h0));

        // random operations, weighted toward add, tick and dispatch
        for (int k = 0; k < RANDOM_OPS; k++) begin
            if (k > RANDOM_OPS * 85 / 100) quiet = 1'b1;
            pick = $urandom_range(0, 99);
            op = row(FUNC_TICK, 8'($urandom_range(0, 255)), 0, 0,
                     4'($urandom_range(0, 15)));
            if (pick < 30) begin
                op.func = FUNC_ADD;
                op.delay_ms  = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 80);
                op.period_ms = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 60);
            end else if (pick < 62) begin
                op.func = FUNC_TICK;
            end else if (pick < 84) begin
                op.func = FUNC_DISPATCH;
            end else if (pick < 93) begin
                op.func = FUNC_DELETE;
            end else if (pick < 96) begin
                op.func = FUNC_CLEAR;
            end else begin
                op.func = 3'($urandom_range(5, 7));
            end
            send(op);
        end
        s_tvalid <= 1'b0;

        wait (outcome_q.size() == 0);
        repeat (40) @(posedge aclk);
        if (errors == 0)
            $display("periodic_task_timer_table_core regression: pass");
        else
            $display("periodic_task_timer_table_core regression: fail");
        $finish;
    end

endmodule
